// ===== hw/rtl/box_blur_3x3_edge_aware_top_macros.svh =====
// ----------------------------------------------------------------------------
// box blur assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH

// antecedent and consequent in the same cycle
`define BBLUR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define BBLUR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg
// types, constants and the reciprocal table shared by the box blur block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bblur_pkg;

  // geometry and field widths
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int IMG_W_W       = 11;
  localparam int ROW_W         = 16;
  localparam int IN_ROW_W      = ROW_W + 1;
  localparam int TAPS          = 9;
  localparam int SUM_W         = 12;
  localparam int X_W           = SUM_W + 1;
  localparam int CNT_W         = 4;
  localparam int RECIP_W       = 24;
  localparam int RECIP_SHIFT   = 24;
  localparam int PROD_W        = X_W + RECIP_W;
  localparam int BANKS         = 4;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 768;

  // input word
  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pixel_in_t;

  // result word
  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } blur_out_t;

  // per-word control from the position tracker
  typedef struct packed {
    logic             step;
    logic             wr_en;
    logic [1:0]       bank;
    logic [1:0]       sel_mid;
    logic [1:0]       sel_top;
    logic             has_out;
    logic             last;
    logic [2:0]       rmask;
    logic [2:0]       cmask;
    logic [CNT_W-1:0] count;
  } step_t;

  // ceil(2^24 / (2*n)) for every neighbour count that can occur
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    unique case (n)
      4'd1:    recip = 24'd8388608;
      4'd2:    recip = 24'd4194304;
      4'd3:    recip = 24'd2796203;
      4'd4:    recip = 24'd2097152;
      4'd6:    recip = 24'd1398102;
      4'd9:    recip = 24'd932068;
      default: recip = 24'd0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/bblur_ram.sv =====
// ----------------------------------------------------------------------------
// bblur_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bblur_pos.sv =====
// ----------------------------------------------------------------------------
// bblur_pos
// frame geometry registers and input / output raster position tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bblur_pos import bblur_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         command,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output step_t                        info,
  output logic [$clog2(MAX_WIDTH)-1:0] col_addr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int W_RESET_EFF = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;
  localparam logic [CW-1:0]    W_LAST_RESET = CW'(W_RESET_EFF - 1);
  localparam logic [ROW_W-1:0] H_LAST_RESET = ROW_W'(HEIGHT_RESET - 1);

  logic [CW-1:0]       w_last;
  logic [ROW_W-1:0]    h_last;
  logic [CW-1:0]       in_col;
  logic [IN_ROW_W-1:0] in_row;
  logic [CW-1:0]       out_col;
  logic [ROW_W-1:0]    out_row;

  logic [CW-1:0]       w_last_next;
  logic [ROW_W-1:0]    h_last_next;
  logic [IMG_W_W-1:0]  wv;
  logic [ROW_W-1:0]    hv;
  logic                in_frame;
  logic                primed;
  logic                top_ok, bot_ok, left_ok, right_ok;
  logic [1:0]          rows_n, cols_n;

  // clamp written geometry: zero acts as one, width capped at the store depth
  always_comb begin
    wv = cfg_data[IMG_W_W-1:0];
    hv = cfg_data[ROW_W-1:0];
    if (wv == '0) begin
      w_last_next = '0;
    end else if (32'(wv) > 32'(MAX_WIDTH)) begin
      w_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_next = CW'(wv - 11'd1);
    end
    h_last_next = (hv == '0) ? '0 : hv - 16'd1;
  end

  // window borders and neighbour count for the next result
  always_comb begin
    in_frame = (in_row <= {1'b0, h_last});
    primed   = (in_row[IN_ROW_W-1:1] != '0) || (in_row[0] && (in_col != '0));
    top_ok   = (out_row != '0);
    bot_ok   = (out_row != h_last);
    left_ok  = (out_col != '0);
    right_ok = (out_col != w_last);
    rows_n   = 2'd1 + 2'(top_ok) + 2'(bot_ok);
    cols_n   = 2'd1 + 2'(left_ok) + 2'(right_ok);

    // a drain word inside the frame is dropped
    info.step    = accept && !(command && in_frame);
    info.wr_en   = info.step && in_frame;
    info.bank    = in_row[1:0];
    info.sel_mid = in_row[1:0] - 2'd1;
    info.sel_top = in_row[1:0] - 2'd2;
    info.has_out = primed;
    info.last    = (out_row == h_last) && (out_col == w_last);
    info.rmask   = {bot_ok, 1'b1, top_ok};
    info.cmask   = {right_ok, 1'b1, left_ok};
    info.count   = CNT_W'(rows_n) * CNT_W'(cols_n);
  end

  assign col_addr = in_col;

  // geometry and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= W_LAST_RESET;
      h_last  <= H_LAST_RESET;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  w_last <= w_last_next;
        REG_IMAGE_HEIGHT: h_last <= h_last_next;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (info.step) begin
      if (primed && info.last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_col == w_last) begin
          in_col <= '0;
          in_row <= in_row + 17'd1;
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (primed) begin
          if (out_col == w_last) begin
            out_col <= '0;
            out_row <= out_row + 16'd1;
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/bblur_lane.sv =====
// ----------------------------------------------------------------------------
// bblur_lane
// one colour channel: masked window sum, then rounded mean by reciprocal
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bblur_lane import bblur_pkg::*; (
  input  logic                       clk,
  input  logic                       load_sum,
  input  logic                       load_out,
  input  logic [TAPS-1:0][CH_W-1:0]  taps,
  input  logic [TAPS-1:0]            mask,
  input  logic [CNT_W-1:0]           count,
  output logic [CH_W-1:0]            mean
);

  logic [SUM_W-1:0]   sum;
  logic [X_W-1:0]     x;
  logic [X_W-1:0]     x_q;
  logic [RECIP_W-1:0] recip_q;
  logic [PROD_W-1:0]  prod;

  // sum of the in-bounds neighbours
  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (mask[i]) begin
        sum = sum + SUM_W'(taps[i]);
      end
    end
  end

  // 2*sum + count, rounding half up once divided by 2*count
  assign x = {sum, 1'b0} + X_W'(count);

  always_ff @(posedge clk) begin
    if (load_sum) begin
      x_q     <= x;
      recip_q <= recip(count);
    end
  end

  // divide by 2*count as a multiply by its reciprocal
  assign prod = PROD_W'(x_q) * PROD_W'(recip_q);

  always_ff @(posedge clk) begin
    if (load_out) begin
      mean <= prod[RECIP_SHIFT +: CH_W];
    end
  end

endmodule

// ===== hw/rtl/box_blur_3x3_edge_aware_top.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top: edge-aware 3x3 box blur over an rgb raster
// a result is due at the word that completes its window (image_width + 1 words later)
// 1 word per cycle unless the output stalls, set by the four dual-port line store banks
// reset: synchronous rst clears positions and pipeline, geometry 1024 x 768
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_top import bblur_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_in_t              pixel,
  output logic                   blur_valid,
  input  logic                   blur_ready,
  output blur_out_t              blur,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  step_t                  info;
  logic [CW-1:0]          col_addr;
  logic                   accept;
  logic [PIX_W-1:0]       pix;
  logic [BANKS-1:0][PIX_W-1:0] bank_rd;

  // pipeline flags
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready, out_free;
  logic s1_move, s2_move, s3_move;

  // stage 1: line store read in flight
  logic             s1_out;
  logic [PIX_W-1:0] s1_pix;
  logic [1:0]       s1_sel_mid, s1_sel_top;
  logic [2:0]       s1_rmask, s1_cmask;
  logic [CNT_W-1:0] s1_count;
  logic             s1_last;

  // stage 2: window, columns left to right, rows top to bottom
  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0]       s2_rmask, s2_cmask;
  logic [CNT_W-1:0] s2_count;
  logic             s2_last;

  // stage 3 and output
  logic             s3_last;
  logic             frame_end;
  logic [2:0][TAPS-1:0][CH_W-1:0] lane_taps;
  logic [TAPS-1:0]  tap_mask;
  logic [2:0][CH_W-1:0] lane_mean;

  // handshake and stall chain
  always_comb begin
    out_free    = !blur_valid || blur_ready;
    s3_ready    = !s3_valid || out_free;
    s3_move     = s3_valid && out_free;
    s2_ready    = !s2_valid || s3_ready;
    s2_move     = s2_valid && s3_ready;
    s1_ready    = !s1_valid || s2_ready;
    s1_move     = s1_valid && s2_ready;
    pixel_ready = s1_ready;
    accept      = pixel_valid && pixel_ready;
    pix         = {pixel.red_in, pixel.green_in, pixel.blue_in};
  end

  // raster positions and geometry
  bblur_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (pixel.command),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (info),
    .col_addr  (col_addr)
  );

  // line stores, one bank per row modulo four
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    bblur_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (info.wr_en && (info.bank == 2'(b))),
      .waddr (col_addr),
      .wdata (pix),
      .re    (info.step),
      .raddr (col_addr),
      .rdata (bank_rd[b])
    );
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      blur_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= info.step;
      end
      if (s2_ready) begin
        s2_valid <= s1_move && s1_out;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        blur_valid <= s3_valid;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (info.step) begin
      s1_out     <= info.has_out;
      s1_pix     <= pix;
      s1_sel_mid <= info.sel_mid;
      s1_sel_top <= info.sel_top;
      s1_rmask   <= info.rmask;
      s1_cmask   <= info.cmask;
      s1_count   <= info.count;
      s1_last    <= info.last;
    end
  end

  // window shift: the new column is two stored rows over the incoming pixel
  always_ff @(posedge clk) begin
    if (s1_move) begin
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= bank_rd[s1_sel_top];
      win[2][1] <= bank_rd[s1_sel_mid];
      win[2][2] <= s1_pix;
      s2_rmask  <= s1_rmask;
      s2_cmask  <= s1_cmask;
      s2_count  <= s1_count;
      s2_last   <= s1_last;
    end
  end

  // frame end flag follows the lanes
  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_last <= s2_last;
    end
    if (s3_move) begin
      frame_end <= s3_last;
    end
  end

  // neighbour mask from row and column borders
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        tap_mask[c*3+r] = s2_cmask[c] && s2_rmask[r];
      end
    end
  end

  // one lane per colour channel
  for (genvar g = 0; g < 3; g++) begin : g_lane
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          lane_taps[g][c*3+r] = win[c][r][CH_W*(2-g) +: CH_W];
        end
      end
    end

    bblur_lane u_lane (
      .clk      (clk),
      .load_sum (s2_move),
      .load_out (s3_move),
      .taps     (lane_taps[g]),
      .mask     (tap_mask),
      .count    (s2_count),
      .mean     (lane_mean[g])
    );
  end

  // merge lanes into the result word
  always_comb begin
    blur.red_out   = lane_mean[0];
    blur.green_out = lane_mean[1];
    blur.blue_out  = lane_mean[2];
    blur.frame_end = frame_end;
  end

endmodule

// ===== hw/rtl/bblur_checker.sv =====
// ----------------------------------------------------------------------------
// bblur_checker
// port-level checks on box blur input ready and result, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "box_blur_3x3_edge_aware_top_macros.svh"

module bblur_checker import bblur_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      pixel_valid,
  input logic      pixel_ready,
  input logic      blur_valid,
  input logic      blur_ready,
  input blur_out_t blur
);

  logic pixel_seen;

  // a word is offered or input is ready this cycle, keeps the input port in use
  assign pixel_seen = pixel_valid || pixel_ready;

  // a stalled result word holds
  `BBLUR_ASSERT_NXT(a_result_hold, blur_valid && !blur_ready, blur_valid && $stable(blur), "result word changed while stalled")

  // the pipeline comes out of reset empty
  `BBLUR_ASSERT_IMP(a_reset_empty, $past(rst), !blur_valid, "result valid straight after reset")

  // with the output register free, every stage can move and input is ready
  `BBLUR_ASSERT_IMP(a_ready_free, (!blur_valid || blur_ready) && pixel_seen, pixel_ready, "input stalled with output free")

endmodule

bind box_blur_3x3_edge_aware_top bblur_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_ready (pixel_ready),
  .blur_valid  (blur_valid),
  .blur_ready  (blur_ready),
  .blur        (blur)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for box_blur_3x3_edge_aware_top
// drives rgb pixel words and drain ticks through the valid/ready input, keeps
// its own line rows and positions to work out every blurred word, and checks
// each result word against the oldest expected one under random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bblur_pkg::*;

  localparam logic CMD_PIXEL     = 1'b0;
  localparam logic CMD_DRAIN     = 1'b1;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   RANDOM_WORDS  = 440;
  localparam int   WIDE_WORDS    = 120;

  logic                   clk;
  logic                   rst;
  logic                   pixel_valid;
  logic                   pixel_ready;
  pixel_in_t              pixel;
  logic                   blur_valid;
  logic                   blur_ready;
  blur_out_t              blur;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // blur predictor state
  logic [PIX_W-1:0]   line_rows [BANKS][MAX_WIDTH_DEF];
  logic [IMG_W_W-1:0] geom_width;
  logic [ROW_W-1:0]   geom_height;
  int                 in_col;
  int                 in_row;
  int                 out_col;
  int                 out_row;
  blur_out_t          blur_expected [$];

  int words_used;
  int err_count;
  int quiet_cycles;
  bit idle_en;

  box_blur_3x3_edge_aware_top #(
    .MAX_WIDTH(MAX_WIDTH_DEF)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .blur_valid(blur_valid),
    .blur_ready(blur_ready),
    .blur(blur),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // effective geometry: zero acts as one, width clipped to the line store
  function automatic int eff_width();
    if (geom_width == '0) return 1;
    if (geom_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(geom_width);
  endfunction

  function automatic int eff_height();
    return (geom_height == '0) ? 1 : int'(geom_height);
  endfunction

  function automatic void restart_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // expected effect of one accepted input word
  function automatic void blur_predict(input pixel_in_t word);
    int               wd;
    int               ht;
    int               rr;
    int               cc;
    int unsigned      cnt;
    int unsigned      sum_r;
    int unsigned      sum_g;
    int unsigned      sum_b;
    logic [PIX_W-1:0] nb;
    bit               primed;
    blur_out_t        res;
    wd = eff_width();
    ht = eff_height();
    // drain tick while pixels are still due: ignored
    if (word.command == CMD_DRAIN && in_row < ht) return;
    words_used++;
    // pixels past the last row only count as drain ticks
    if (in_row < ht) begin
      line_rows[in_row & 3][in_col] = {word.red_in, word.green_in, word.blue_in};
    end
    primed = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= wd) begin
      in_col = 0;
      in_row++;
    end
    if (!primed) return;
    // mean over the in-bounds neighbours
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt   = 0;
    for (rr = out_row - 1; rr <= out_row + 1; rr++) begin
      for (cc = out_col - 1; cc <= out_col + 1; cc++) begin
        if (rr >= 0 && rr < ht && cc >= 0 && cc < wd) begin
          nb = line_rows[rr & 3][cc];
          sum_r += nb[23:16];
          sum_g += nb[15:8];
          sum_b += nb[7:0];
          cnt++;
        end
      end
    end
    res.red_out   = 8'((2 * sum_r + cnt) / (2 * cnt));
    res.green_out = 8'((2 * sum_g + cnt) / (2 * cnt));
    res.blue_out  = 8'((2 * sum_b + cnt) / (2 * cnt));
    res.frame_end = (out_row == ht - 1) && (out_col == wd - 1);
    blur_expected.push_back(res);
    if (res.frame_end) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= wd) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic pixel_in_t word_of(input logic cmd, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
    word_of = '{command: cmd, red_in: r, green_in: g, blue_in: b};
  endfunction

  function automatic pixel_in_t rand_word(input logic cmd);
    return word_of(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      err_count++;
    end
  endfunction

  // send one input word, with random idle cycles ahead of it
  task automatic send_word(input pixel_in_t word);
    while (idle_en && $urandom_range(99) < 37) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= word;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    blur_predict(word);
    @(negedge clk);
  endtask

  // flush ticks: mostly drains, some pixels whose data is dropped
  task automatic flush_frame(input int ticks);
    repeat (ticks) begin
      if ($urandom_range(99) < 70) send_word(rand_word(CMD_DRAIN));
      else send_word(rand_word(CMD_PIXEL));
    end
  endtask

  // register write once every expected word is out and the pipe has settled
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    pixel_valid <= 1'b0;
    while (blur_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) geom_width = data[IMG_W_W-1:0];
    else geom_height = data[ROW_W-1:0];
    restart_positions();
  endtask

  // reset geometry: nothing is due for the first row, the write abandons it
  task automatic test_reset_geometry();
    send_word(word_of(CMD_PIXEL, 8'h00, 8'h00, 8'h00));
    send_word(word_of(CMD_DRAIN, 8'hff, 8'hff, 8'hff));
    send_word(word_of(CMD_PIXEL, 8'hff, 8'hff, 8'hff));
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
  endtask

  // zero width and height act as a one-pixel frame
  task automatic test_single_pixel_frames();
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    send_word(word_of(CMD_DRAIN, 8'h12, 8'h34, 8'h56));
    send_word(word_of(CMD_PIXEL, 8'ha5, 8'h5a, 8'hff));
    send_word(word_of(CMD_DRAIN, 8'h00, 8'h00, 8'h00));
    send_word(word_of(CMD_DRAIN, 8'hff, 8'hff, 8'hff));
    // back-to-back frame, a pixel standing in for a drain tick
    send_word(word_of(CMD_PIXEL, 8'h00, 8'hff, 8'h00));
    send_word(word_of(CMD_PIXEL, 8'hff, 8'h00, 8'hff));
    send_word(word_of(CMD_DRAIN, 8'h00, 8'h00, 8'h00));
  endtask

  // 3 x 3 frame: corners, edges and one full interior window
  task automatic test_small_frame();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    for (int i = 0; i < 9; i++) begin
      send_word(word_of(CMD_PIXEL, (i & 1) ? 8'hff : 8'h00,
                        (i & 2) ? 8'haa : 8'h55, 8'(i * 29)));
      if (i == 4) send_word(word_of(CMD_DRAIN, 8'h00, 8'hff, 8'h00));
    end
    send_word(word_of(CMD_DRAIN, 8'h00, 8'h00, 8'h00));
    send_word(word_of(CMD_PIXEL, 8'hff, 8'hff, 8'hff));
    send_word(word_of(CMD_DRAIN, 8'hff, 8'hff, 8'hff));
    send_word(word_of(CMD_DRAIN, 8'h00, 8'h00, 8'h00));
  endtask

  // widest row, width field above the store size, left unfinished, no idling
  task automatic test_wide_row();
    write_reg(REG_IMAGE_WIDTH, 16'hffff);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    idle_en = 1'b0;
    repeat (WIDE_WORDS) send_word(rand_word(CMD_PIXEL));
    idle_en = 1'b1;
  endtask

  // one column at the tallest height, left unfinished
  task automatic test_tall_column();
    write_reg(REG_IMAGE_WIDTH, 16'd1);
    write_reg(REG_IMAGE_HEIGHT, 16'hffff);
    for (int i = 0; i < 40; i++) begin
      send_word(rand_word(CMD_PIXEL));
      if (i % 13 == 5) send_word(rand_word(CMD_DRAIN));
    end
  endtask

  // random geometries, mostly whole frames with some cut short
  task automatic test_random_frames();
    int                    goal;
    int                    round;
    int                    w_raw;
    int                    h_raw;
    int                    sel;
    int                    n_pix;
    int                    total;
    int                    cut;
    logic [CFG_DATA_W-1:0] data;
    bit                    cut_short;
    goal  = words_used + RANDOM_WORDS;
    round = 0;
    while (words_used < goal) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        w_raw = $urandom_range(1, 8);
        h_raw = $urandom_range(1, 6);
      end else if (sel < 90) begin
        w_raw = $urandom_range(9, 40);
        h_raw = $urandom_range(1, 4);
      end else begin
        w_raw = $urandom_range(0, 2);
        h_raw = $urandom_range(0, 3);
      end
      // junk in the width field's unused upper bits
      data                = CFG_DATA_W'($urandom);
      data[IMG_W_W-1:0]   = IMG_W_W'(w_raw);
      write_reg(REG_IMAGE_WIDTH, data);
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_raw));
      idle_en   = !(round >= 4 && round < 8);
      n_pix     = eff_width() * eff_height();
      total     = n_pix + eff_width() + 1;
      cut_short = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        if (!cut_short) begin
          cut_short = ($urandom_range(99) < 12);
          cut       = cut_short ? $urandom_range(1, total - 1) : total;
          for (int n = 0; n < cut; n++) begin
            if (n < n_pix) begin
              if ($urandom_range(99) < 8) send_word(rand_word(CMD_DRAIN));
              send_word(rand_word(CMD_PIXEL));
            end else begin
              flush_frame(1);
            end
          end
        end
      end
      round++;
    end
    idle_en = 1'b1;
  endtask

  // receiver stalls
  initial begin
    blur_ready = 1'b0;
    forever begin
      @(negedge clk);
      blur_ready <= !(idle_en && $urandom_range(99) < 37);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin : result_check
    blur_out_t want;
    if (!rst && blur_valid && blur_ready) begin
      if (blur_expected.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, blur);
        err_count++;
      end else begin
        want = blur_expected.pop_front();
        check_field("red_out", want.red_out, blur.red_out);
        check_field("green_out", want.green_out, blur.green_out);
        check_field("blue_out", want.blue_out, blur.blue_out);
        check_field("frame_end", want.frame_end, blur.frame_end);
      end
    end
    if ((pixel_valid && pixel_ready) || (blur_valid && blur_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_en      = 1'b1;
    err_count    = 0;
    quiet_cycles = 0;
    words_used   = 0;
    geom_width   = IMG_W_W'(WIDTH_RESET);
    geom_height  = ROW_W'(HEIGHT_RESET);
    for (int b = 0; b < BANKS; b++) begin
      for (int c = 0; c < MAX_WIDTH_DEF; c++) line_rows[b][c] = '0;
    end
    restart_positions();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_single_pixel_frames();
    test_small_frame();
    test_wide_row();
    test_tall_column();
    test_random_frames();

    // drain out and allow for late extra words
    pixel_valid <= 1'b0;
    while (blur_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
